/* design/lbs_pkg.sv */
// Shared types and constants for the LED blink sequencer.
`default_nettype none
package lbs_pkg;

	localparam int NUM_LEDS_DEF = 4;
	localparam int SEL_W        = 2;
	localparam int NUM_SEL      = 1 << SEL_W;
	localparam int OUT_W        = 4;
	localparam int CNT_W        = 16;
	localparam int TOG_W        = 32;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;
	localparam int REG_IDX_BIT  = 2;

	localparam logic REG_LAMP_TICKS = 1'b0;

	localparam logic [CNT_W-1:0] LAMP_TICKS_RST = 16'd2000;
	localparam logic [CNT_W-1:0] CNT_MAX        = '1;
	localparam logic [TOG_W-1:0] TOG_MAX        = '1;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_SET   = 2'd1,
		CMD_BLINK = 2'd2,
		CMD_LAMP  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic on;
		logic on_next;
		logic tick_run;
		logic lamp_end;
	} lamp_stat_t;

	typedef struct packed {
		cmd_t             command;
		logic             lamp_on;
		logic             tick_run;
		logic             lamp_end;
		logic             level;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] half;
	} lane_ctl_t;

	typedef struct packed {
		logic driven;
		logic active;
	} lane_out_t;

	typedef struct packed {
		logic [OUT_W-1:0] led_outputs;
		logic [OUT_W-1:0] blinking_mask;
		logic             lamp_test_on;
	} result_t;

endpackage
`default_nettype wire

/* design/lbs_if.sv */
// Command and result channel interfaces.
`default_nettype none
interface lbs_cmd_if;
	import lbs_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       command;
	logic [SEL_W-1:0] led_select;
	logic             steady_level;
	logic [CNT_W-1:0] blink_count;
	logic [CNT_W-1:0] half_period;

	modport source (
		output valid, command, led_select, steady_level, blink_count, half_period,
		input  ready
	);
	modport sink (
		input  valid, command, led_select, steady_level, blink_count, half_period,
		output ready
	);
endinterface

interface lbs_res_if;
	import lbs_pkg::*;
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] led_outputs;
	logic [OUT_W-1:0] blinking_mask;
	logic             lamp_test_on;

	modport source (
		output valid, led_outputs, blinking_mask, lamp_test_on,
		input  ready
	);
	modport sink (
		input  valid, led_outputs, blinking_mask, lamp_test_on,
		output ready
	);
endinterface
`default_nettype wire

/* design/lbs_cfg_regs.sv */
// APB configuration register bank: lamp test length.
`default_nettype none
module lbs_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lbs_pkg::APB_AW-1:0]  paddr,
	input  logic [lbs_pkg::APB_DW-1:0]  pwdata,
	output logic [lbs_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [lbs_pkg::CNT_W-1:0]   lamp_ticks
);
	import lbs_pkg::*;

	logic [CNT_W-1:0] lamp_ticks_q;
	logic             sel_lamp;
	logic             wr_en;

	assign sel_lamp = (paddr[REG_IDX_BIT] == REG_LAMP_TICKS);
	assign wr_en    = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_ticks_q <= LAMP_TICKS_RST;
		end else if (wr_en && sel_lamp) begin
			lamp_ticks_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata     = sel_lamp ? {{(APB_DW-CNT_W){1'b0}}, lamp_ticks_q} : '0;
	assign lamp_ticks = lamp_ticks_q;

endmodule
`default_nettype wire

/* design/lbs_lamp_timer.sv */
// Lamp test flag and elapsed tick counter.
`default_nettype none
module lbs_lamp_timer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  lbs_pkg::cmd_t             command,
	input  logic [lbs_pkg::CNT_W-1:0] lamp_ticks,
	output lbs_pkg::lamp_stat_t       stat
);
	import lbs_pkg::*;

	logic             flag_q, flag_d;
	logic [CNT_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic             lamp_end;

	assign elapsed_inc = (elapsed_q == CNT_MAX) ? elapsed_q : elapsed_q + CNT_W'(1);
	assign lamp_end    = flag_q && (elapsed_inc >= lamp_ticks);

	always_comb begin
		flag_d    = flag_q;
		elapsed_d = elapsed_q;
		if (en) begin
			case (command)
				CMD_TICK: begin
					if (flag_q) begin
						elapsed_d = elapsed_inc;
						if (lamp_end) begin
							flag_d = 1'b0;
						end
					end
				end
				CMD_LAMP: begin
					flag_d    = 1'b1;
					elapsed_d = '0;
				end
				default: begin
				end
			endcase
		end
		stat.on       = flag_q;
		stat.on_next  = flag_d;
		stat.lamp_end = lamp_end;
		stat.tick_run = !flag_q || lamp_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= 1'b1;
			elapsed_q <= '0;
		end else begin
			flag_q    <= flag_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule
`default_nettype wire

/* design/lbs_led_lane.sv */
// Per-LED state: steady level, driven level and blink run.
`default_nettype none
module lbs_led_lane #(
	parameter logic RESET_STEADY = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               hit,
	input  lbs_pkg::lane_ctl_t ctl,
	output lbs_pkg::lane_out_t lo
);
	import lbs_pkg::*;

	logic             steady_q, steady_d;
	logic             driven_q, driven_d;
	logic             active_q, active_d;
	logic [TOG_W-1:0] toggles_q, toggles_d;
	logic [CNT_W-1:0] half_q, half_d;
	logic [CNT_W-1:0] since_q, since_d;

	logic             run_ok;
	logic [CNT_W-1:0] since_base, since_inc;
	logic [CNT_W-1:0] half_eff;
	logic [TOG_W-1:0] add;
	logic [TOG_W:0]   sum;
	logic             do_tog;
	logic [TOG_W-1:0] tog_cnt, tog_dec;

	assign run_ok   = active_q && (half_q != '0);
	assign half_eff = (ctl.half == '0) ? CNT_W'(1) : ctl.half;
	assign add      = {{(TOG_W-CNT_W-1){1'b0}}, ctl.count, 1'b0};
	assign sum      = {1'b0, toggles_q} + {1'b0, add};

	always_comb begin
		steady_d   = steady_q;
		driven_d   = driven_q;
		active_d   = active_q;
		toggles_d  = toggles_q;
		half_d     = half_q;
		since_d    = since_q;
		do_tog     = 1'b0;
		tog_cnt    = toggles_q;
		since_base = (ctl.lamp_end && run_ok) ? half_q : since_q;
		since_inc  = (since_base == CNT_MAX) ? since_base : since_base + CNT_W'(1);
		if (en) begin
			case (ctl.command)
				CMD_TICK: begin
					if (ctl.tick_run) begin
						if (ctl.lamp_end && !run_ok) begin
							driven_d = steady_q;
						end
						if (run_ok) begin
							since_d = since_inc;
							if (since_inc >= half_q) begin
								since_d = '0;
								do_tog  = 1'b1;
							end
						end
					end
				end
				CMD_SET: begin
					if (hit) begin
						steady_d  = ctl.level;
						active_d  = 1'b0;
						toggles_d = '0;
						half_d    = '0;
						if (!ctl.lamp_on) begin
							driven_d = ctl.level;
						end
					end
				end
				CMD_BLINK: begin
					if (hit && (ctl.count != '0)) begin
						half_d = half_eff;
						if (active_q) begin
							toggles_d = sum[TOG_W] ? TOG_MAX : sum[TOG_W-1:0];
						end else begin
							active_d  = 1'b1;
							since_d   = '0;
							toggles_d = add;
							if (!ctl.lamp_on) begin
								do_tog  = 1'b1;
								tog_cnt = add;
							end
						end
					end
				end
				CMD_LAMP: begin
					driven_d = 1'b1;
				end
				default: begin
				end
			endcase
		end
		tog_dec = (tog_cnt != '0) ? tog_cnt - TOG_W'(1) : '0;
		if (do_tog) begin
			driven_d  = ~driven_d;
			toggles_d = tog_dec;
			if (tog_dec == '0) begin
				active_d  = 1'b0;
				toggles_d = '0;
				half_d    = '0;
				driven_d  = steady_q;
			end
		end
		lo.driven = driven_d;
		lo.active = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steady_q  <= RESET_STEADY;
			driven_q  <= 1'b1;
			active_q  <= 1'b0;
			toggles_q <= '0;
			half_q    <= '0;
			since_q   <= '0;
		end else begin
			steady_q  <= steady_d;
			driven_q  <= driven_d;
			active_q  <= active_d;
			toggles_q <= toggles_d;
			half_q    <= half_d;
			since_q   <= since_d;
		end
	end

endmodule
`default_nettype wire

/* design/lbs_result_buf.sv */
// Two-entry result buffer between the update logic and the result channel.
`default_nettype none
module lbs_result_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lbs_pkg::result_t push_data,
	output logic             full,
	lbs_res_if.source        res
);
	import lbs_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;
	result_t    head;

	assign pop  = res.valid && res.ready;
	assign full = (cnt_q == 2'd2);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	assign res.valid         = (cnt_q != 2'd0);
	assign res.led_outputs   = head.led_outputs;
	assign res.blinking_mask = head.blinking_mask;
	assign res.lamp_test_on  = head.lamp_test_on;

endmodule
`default_nettype wire

/* design/led_blink_sequencer.sv */
// Top level of the LED blink sequencer.
//
//  channel  dir  width  content
//  cmd      in   37     command, led_select, steady_level, blink_count, half_period
//  res      out  9      led_outputs, blinking_mask, lamp_test_on
//  apb      cfg  32     lamp_test_ticks at byte address 0
//
// One command is taken per cycle while cmd.ready holds; its result enters the buffer.
// All LED lanes and the lamp timer update in the cycle of the transfer.
// A two-entry result buffer parts the sides; cmd.ready drops only when both entries wait.
// Reset starts the lamp test with LED0 steady on and no blink runs.
`default_nettype none
module led_blink_sequencer #(
	parameter int NUM_LEDS = lbs_pkg::NUM_LEDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lbs_cmd_if.sink                    cmd,
	lbs_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lbs_pkg::APB_AW-1:0] paddr,
	input  logic [lbs_pkg::APB_DW-1:0] pwdata,
	output logic [lbs_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import lbs_pkg::*;

	logic             accept;
	logic             buf_full;
	cmd_t             command;
	logic [CNT_W-1:0] lamp_ticks;
	lamp_stat_t       lamp_stat;
	lane_ctl_t        ctl;
	lane_out_t        lane_out [NUM_LEDS];
	result_t          result;

	assign command   = cmd_t'(cmd.command);
	assign cmd.ready = !buf_full;
	assign accept    = cmd.valid && cmd.ready;

	lbs_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.lamp_ticks (lamp_ticks)
	);

	lbs_lamp_timer u_lamp (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.command    (command),
		.lamp_ticks (lamp_ticks),
		.stat       (lamp_stat)
	);

	always_comb begin
		ctl.command  = command;
		ctl.lamp_on  = lamp_stat.on;
		ctl.tick_run = lamp_stat.tick_run;
		ctl.lamp_end = lamp_stat.lamp_end;
		ctl.level    = cmd.steady_level;
		ctl.count    = cmd.blink_count;
		ctl.half     = cmd.half_period;
	end

	for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
		logic hit;
		if (i < NUM_SEL) begin : g_sel
			assign hit = (cmd.led_select == SEL_W'(i));
		end else begin : g_nosel
			assign hit = 1'b0;
		end
		lbs_led_lane #(
			.RESET_STEADY (i == 0)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.hit    (hit),
			.ctl    (ctl),
			.lo     (lane_out[i])
		);
	end

	for (genvar j = 0; j < OUT_W; j++) begin : g_bits
		if (j < NUM_LEDS) begin : g_led
			assign result.led_outputs[j]   = lane_out[j].driven;
			assign result.blinking_mask[j] = lane_out[j].active;
		end else begin : g_none
			assign result.led_outputs[j]   = 1'b0;
			assign result.blinking_mask[j] = 1'b0;
		end
	end
	assign result.lamp_test_on = lamp_stat.on_next;

	lbs_result_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (buf_full),
		.res       (res)
	);

endmodule
`default_nettype wire

/* design/lbs_checker.sv */
// Port-level assertions for the LED blink sequencer, bound to the top level.
`default_nettype none
module lbs_checker #(
	parameter int NUM_LEDS = lbs_pkg::NUM_LEDS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cmd_ready,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [lbs_pkg::OUT_W-1:0] led_outputs,
	input logic [lbs_pkg::OUT_W-1:0] blinking_mask,
	input logic                      lamp_test_on
);
	import lbs_pkg::*;

	localparam int SHOWN = (NUM_LEDS < OUT_W) ? NUM_LEDS : OUT_W;
	localparam logic [OUT_W-1:0] LED_MASK = OUT_W'((1 << SHOWN) - 1);

	a_lamp_all_on: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && lamp_test_on |-> (led_outputs == LED_MASK))
		else $error("lamp test result with an LED off");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			res_valid && $stable({led_outputs, blinking_mask, lamp_test_on}))
		else $error("stalled result changed or dropped");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("command stalled with no result waiting");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (((led_outputs | blinking_mask) & ~LED_MASK) == '0))
		else $error("result bit set for an absent LED");

endmodule

bind led_blink_sequencer lbs_checker #(
	.NUM_LEDS (NUM_LEDS)
) u_lbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_ready     (cmd.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.led_outputs   (res.led_outputs),
	.blinking_mask (res.blinking_mask),
	.lamp_test_on  (res.lamp_test_on)
);
`default_nettype wire
